### rtl/bat_pkg.sv
// Shared constants, codes and types for the button autofire block.
package bat_pkg;

    localparam int TIME_W    = 32;
    localparam int TAP_W     = 6;
    localparam int BTN_N     = 4;
    localparam int ADDR_W    = 4;
    localparam int DATA_W    = 32;
    localparam int MODE_W    = 2;
    localparam int DEF_LANES = 4;

    localparam logic [TAP_W-1:0]  TAP_MAX    = 6'd63;
    localparam logic [MODE_W-1:0] RST_MODE   = 2'd1;
    localparam logic [TIME_W-1:0] RST_WINDOW = 32'd200000;
    localparam logic [TIME_W-1:0] RST_PERIOD = 32'd75000;
    localparam logic [TAP_W-1:0]  RST_TAPS   = 6'd2;

    typedef enum logic [MODE_W-1:0] {
        MODE_PASS   = 2'd0,
        MODE_ASSIST = 2'd1,
        MODE_TOGGLE = 2'd2
    } bat_mode_t;

    typedef enum logic [1:0] {
        REG_FIRE_MODE    = 2'd0,
        REG_TAP_WINDOW   = 2'd1,
        REG_PULSE_PERIOD = 2'd2,
        REG_TAPS_NEEDED  = 2'd3
    } bat_reg_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_LANE,
        ST_WAIT,
        ST_FINISH
    } bat_state_t;

    // Status returned by the serial divider.
    typedef struct packed {
        logic done;
        logic odd;
    } bat_div_stat_t;

endpackage

### rtl/bat_div.sv
// Bit-serial restoring divider that reports the parity of the quotient.
module bat_div
    import bat_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  logic [TIME_W-1:0]   dividend,
    input  logic [TIME_W-1:0]   divisor,
    output bat_div_stat_t       stat
);

    localparam int CNT_W = $clog2(TIME_W + 1);

    logic [TIME_W:0]    rem_reg;
    logic [TIME_W:0]    rem_next;
    logic [TIME_W-1:0]  dvd_reg;
    logic [TIME_W-1:0]  dsr_reg;
    logic [CNT_W-1:0]   cnt_reg;
    logic               run_reg;
    logic               done_reg;
    logic               odd_reg;
    logic [TIME_W:0]    rem_sh;
    logic [TIME_W+1:0]  diff;
    logic               qbit;

    // One quotient bit per cycle: shift in the next dividend bit and try the subtract.
    always_comb
    begin
        rem_sh   = {rem_reg[TIME_W-1:0], dvd_reg[TIME_W-1]};
        diff     = {1'b0, rem_sh} - {2'b00, dsr_reg};
        qbit     = ~diff[TIME_W+1];
        rem_next = qbit ? diff[TIME_W:0] : rem_sh;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                run_reg <= 1'b1;
                cnt_reg <= CNT_W'(TIME_W);
            end
            else if (run_reg)
            begin
                cnt_reg <= cnt_reg - CNT_W'(1);
                if (cnt_reg == CNT_W'(1))
                begin
                    run_reg  <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= '0;
            dvd_reg <= dividend;
            dsr_reg <= (divisor == '0) ? TIME_W'(1) : divisor;
        end
        else if (run_reg)
        begin
            rem_reg <= rem_next;
            dvd_reg <= {dvd_reg[TIME_W-2:0], 1'b0};
            odd_reg <= qbit;
        end
    end

    assign stat.done = done_reg;
    assign stat.odd  = odd_reg;

endmodule

### rtl/button_autofire_tap_toggle_core.sv
// Top level of the button autofire block: configuration registers, lane sequencer and output.
//
// Each input beat carries a timestamp, the fire button levels and the toggle button level,
// and yields exactly one output beat of processed fire levels. In tap assist and toggle
// modes the lanes are handled one after another, each taking a set-up state (ST_LANE) and
// then a run of the shared bit-serial divider that finds the pulse phase; in pass-through
// modes the sample goes straight to the finish state. A new beat is taken while the
// previous result still waits on the output.
// Configuration should only be written while no beat is in flight.
module button_autofire_tap_toggle_core
    import bat_pkg::*;
#(
    parameter int LANES = DEF_LANES
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [ADDR_W-1:0]   paddr,
    input  logic [DATA_W-1:0]   pwdata,
    output logic [DATA_W-1:0]   prdata,
    output logic                pready,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [39:0]         s_tdata,    // time_us[31:0], pressed_bits[35:32], toggle_level[36]
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [7:0]          m_tdata     // fire_bits[3:0]
);

    localparam int LANE_W = (LANES > 1) ? $clog2(LANES) : 1;

    // Configuration registers
    logic [MODE_W-1:0]  mode_reg;
    logic [TIME_W-1:0]  win_reg;
    logic [TIME_W-1:0]  per_reg;
    logic [TAP_W-1:0]   need_reg;

    // Lane state
    logic [TIME_W-1:0]  stamp_reg [LANES];
    logic [TAP_W-1:0]   taps_reg  [LANES];
    logic [LANES-1:0]   prev_reg;
    logic [LANES-1:0]   en_reg;

    // Sample and sequencing
    bat_state_t         state_reg, state_next;
    logic [LANE_W-1:0]  lane_reg, lane_next;
    logic [TIME_W-1:0]  time_reg;
    logic [BTN_N-1:0]   pbits_reg;
    logic               tog_reg;
    logic [LANES-1:0]   res_reg, res_next;
    logic               m_tvalid_reg, m_tvalid_next;
    logic [BTN_N-1:0]   fire_reg, fire_next;

    logic [LANES-1:0]   press_vec;
    logic [LANES-1:0]   press_in;
    logic [BTN_N-1:0]   fire_vec;

    logic               div_start;
    bat_div_stat_t      div_stat;

    logic               upd_en;
    logic [TIME_W-1:0]  elapsed;
    logic               in_window;
    logic               pressed;
    logic               prev;
    logic [TAP_W-1:0]   taps;
    logic               en;
    logic               pulse;
    logic [TIME_W-1:0]  stamp_next;
    logic [TAP_W-1:0]   taps_next;
    logic               prev_next;
    logic               en_next;
    logic               lane_out;
    logic               cfg_wr;
    logic               in_acc;

    assign pready   = 1'b1;
    assign cfg_wr   = psel && penable && pwrite;
    assign s_tready = (state_reg == ST_IDLE);
    assign in_acc   = s_tvalid && s_tready;
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {4'b0000, fire_reg};

    // Only the first four lanes have a button behind them and reach the output.
    for (genvar i = 0; i < LANES; i++)
    begin : g_lane_map
        if (i < BTN_N)
        begin : g_btn
            assign press_vec[i] = pbits_reg[i];
            assign press_in[i]  = s_tdata[TIME_W + i];
        end
        else
        begin : g_none
            assign press_vec[i] = 1'b0;
            assign press_in[i]  = 1'b0;
        end
    end

    for (genvar i = 0; i < BTN_N; i++)
    begin : g_out_map
        if (i < LANES)
        begin : g_used
            assign fire_vec[i] = res_reg[i];
        end
        else
        begin : g_unused
            assign fire_vec[i] = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= RST_MODE;
            win_reg  <= RST_WINDOW;
            per_reg  <= RST_PERIOD;
            need_reg <= RST_TAPS;
        end
        else if (cfg_wr)
        begin
            case (bat_reg_t'(paddr[3:2]))
                REG_FIRE_MODE:    mode_reg <= pwdata[MODE_W-1:0];
                REG_TAP_WINDOW:   win_reg  <= pwdata[TIME_W-1:0];
                REG_PULSE_PERIOD: per_reg  <= pwdata[TIME_W-1:0];
                REG_TAPS_NEEDED:  need_reg <= pwdata[TAP_W-1:0];
                default:          ;
            endcase
        end
    end

    always_comb
    begin
        case (bat_reg_t'(paddr[3:2]))
            REG_FIRE_MODE:    prdata = {{(DATA_W-MODE_W){1'b0}}, mode_reg};
            REG_TAP_WINDOW:   prdata = win_reg;
            REG_PULSE_PERIOD: prdata = per_reg;
            REG_TAPS_NEEDED:  prdata = {{(DATA_W-TAP_W){1'b0}}, need_reg};
            default:          prdata = '0;
        endcase
    end

    bat_div u_div
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (elapsed),
        .divisor  (per_reg),
        .stat     (div_stat)
    );

    // Per-lane update of the lane currently selected; the stamp is unchanged until it runs.
    always_comb
    begin
        elapsed    = time_reg - stamp_reg[lane_reg];
        in_window  = elapsed < win_reg;
        pressed    = press_vec[lane_reg];
        prev       = prev_reg[lane_reg];
        taps       = taps_reg[lane_reg];
        en         = en_reg[lane_reg];
        pulse      = ~div_stat.odd;
        stamp_next = stamp_reg[lane_reg];
        taps_next  = taps;
        prev_next  = prev;
        en_next    = en;
        lane_out   = pressed;
        if (mode_reg == MODE_ASSIST)
        begin
            if (pressed && !prev)
            begin
                stamp_next = time_reg;
                if (in_window && taps != TAP_MAX)
                begin
                    taps_next = taps + TAP_W'(1);
                end
            end
            if (!pressed && !in_window)
            begin
                taps_next = '0;
            end
            if (pressed && taps_next >= need_reg)
            begin
                lane_out = pulse;
            end
            prev_next = pressed;
        end
        else
        begin
            if (!pressed)
            begin
                stamp_next = time_reg;
            end
            if (prev && !tog_reg && pressed)
            begin
                en_next = ~en;
            end
            if (en && pressed)
            begin
                lane_out = pulse;
            end
            prev_next = tog_reg;
        end
    end

    always_comb
    begin
        state_next    = state_reg;
        lane_next     = lane_reg;
        res_next      = res_reg;
        fire_next     = fire_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        div_start     = 1'b0;
        upd_en        = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_acc)
                begin
                    lane_next = '0;
                    if (mode_reg == MODE_ASSIST || mode_reg == MODE_TOGGLE)
                    begin
                        state_next = ST_LANE;
                    end
                    else
                    begin
                        res_next   = press_in;
                        state_next = ST_FINISH;
                    end
                end
            end
            ST_LANE:
            begin
                div_start  = 1'b1;
                state_next = ST_WAIT;
            end
            ST_WAIT:
            begin
                if (div_stat.done)
                begin
                    upd_en             = 1'b1;
                    res_next[lane_reg] = lane_out;
                    if (lane_reg == LANE_W'(LANES - 1))
                    begin
                        state_next = ST_FINISH;
                    end
                    else
                    begin
                        lane_next  = lane_reg + LANE_W'(1);
                        state_next = ST_LANE;
                    end
                end
            end
            ST_FINISH:
            begin
                if (!m_tvalid_reg || m_tready)
                begin
                    fire_next     = fire_vec;
                    m_tvalid_next = 1'b1;
                    state_next    = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            lane_reg     <= '0;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            lane_reg     <= lane_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < LANES; i++)
            begin
                stamp_reg[i] <= '0;
                taps_reg[i]  <= '0;
            end
            prev_reg <= '0;
            en_reg   <= '0;
        end
        else if (upd_en)
        begin
            stamp_reg[lane_reg] <= stamp_next;
            taps_reg[lane_reg]  <= taps_next;
            prev_reg[lane_reg]  <= prev_next;
            en_reg[lane_reg]    <= en_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            time_reg  <= s_tdata[TIME_W-1:0];
            pbits_reg <= s_tdata[TIME_W+BTN_N-1:TIME_W];
            tog_reg   <= s_tdata[TIME_W+BTN_N];
        end
        res_reg  <= res_next;
        fire_reg <= fire_next;
    end

`ifndef SYNTHESIS
    // A taken beat starts work, so no second beat is taken in the next cycle.
    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("second beat accepted while one is in flight");

    // The divider only finishes while the sequencer waits on it.
    a_div_done_wait: assert property (@(posedge clk) disable iff (!rst_n)
        div_stat.done |-> state_reg == ST_WAIT)
        else $error("divider finished outside its wait state");

    // Leaving the finish state always presents a result and frees the input.
    a_finish_out: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_FINISH && (!m_tvalid || m_tready) |=> m_tvalid && s_tready)
        else $error("result not presented on leaving finish state");
`endif

endmodule
